// ===== hdl/sle_pkg.sv =====
// Shared types, sizes and codes for the sequential list engine.
`timescale 1ns / 1ps
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef logic signed [31:0] entry_t;

	typedef struct packed {
		op_t                op;
		logic        [4:0]  position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_value;
		logic        [4:0]  found_position;
		logic        [4:0]  count;
	} rsp_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] pos_idx;
		logic [CNT_W-1:0] cnt;
		entry_t           value;
	} cell_ctl_t;

endpackage

// ===== hdl/sle_cell.sv =====
// One list slot: holds an entry, shifts to or from its neighbors, compares for find.
`timescale 1ns / 1ps
module sle_cell (
	input  logic                      clk,
	input  logic [sle_pkg::IDX_W-1:0] idx,
	input  sle_pkg::cell_ctl_t        ctl,
	input  sle_pkg::entry_t           left,
	input  sle_pkg::entry_t           right,
	output sle_pkg::entry_t           entry,
	output logic                      match
);

	sle_pkg::entry_t              entry_q;
	logic [sle_pkg::CMP_W-1:0]    idx_w;
	logic [sle_pkg::CMP_W-1:0]    pos_w;
	logic [sle_pkg::CMP_W-1:0]    cnt_w;

	assign idx_w = sle_pkg::CMP_W'(idx);
	assign pos_w = sle_pkg::CMP_W'(ctl.pos_idx);
	assign cnt_w = sle_pkg::CMP_W'(ctl.cnt);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx_w == pos_w) begin
				entry_q <= ctl.value;
			end else if (idx_w > pos_w && idx_w <= cnt_w) begin
				entry_q <= left;
			end
		end else if (ctl.del) begin
			if (idx_w >= pos_w && (idx_w + sle_pkg::CMP_W'(1)) < cnt_w) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;
	assign match = (idx_w < cnt_w) && (entry_q == ctl.value);

endmodule

// ===== hdl/sle_ctrl.sv =====
// Request decode: range checks, cell controls, next count and the result beat.
`timescale 1ns / 1ps
module sle_ctrl (
	input  logic                         valid,
	input  sle_pkg::req_t                req,
	input  logic [sle_pkg::CNT_W-1:0]    cnt,
	input  sle_pkg::entry_t              entries [sle_pkg::CAPACITY],
	input  logic [sle_pkg::CAPACITY-1:0] match,
	output sle_pkg::cell_ctl_t           ctl,
	output logic [sle_pkg::CNT_W-1:0]    cnt_d,
	output sle_pkg::rsp_t                rsp_d
);

	logic [sle_pkg::CMP_W-1:0] pos_w;
	logic [sle_pkg::CMP_W-1:0] cnt_w;
	logic [sle_pkg::CMP_W-1:0] pos_m1;
	logic [sle_pkg::IDX_W-1:0] pos_idx;
	logic                      ins_ok;
	logic                      rd_ok;
	logic                      full;
	logic                      hit;
	logic [sle_pkg::IDX_W-1:0] hit_idx;
	logic [31:0]               hit_pos;

	assign pos_w   = sle_pkg::CMP_W'(req.position);
	assign cnt_w   = sle_pkg::CMP_W'(cnt);
	assign pos_m1  = pos_w - sle_pkg::CMP_W'(1);
	assign pos_idx = pos_m1[sle_pkg::IDX_W-1:0];
	assign ins_ok  = (req.position != 5'd0) && (pos_w <= cnt_w + sle_pkg::CMP_W'(1));
	assign rd_ok   = (req.position != 5'd0) && (pos_w <= cnt_w);
	assign full    = (cnt == sle_pkg::CNT_W'(sle_pkg::CAPACITY));

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = sle_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = sle_pkg::IDX_W'(i);
			end
		end
	end

	assign hit_pos = 32'(hit_idx) + 32'd1;

	always_comb begin
		ctl.ins     = 1'b0;
		ctl.del     = 1'b0;
		ctl.pos_idx = pos_idx;
		ctl.cnt     = cnt;
		ctl.value   = req.value;
		cnt_d       = cnt;
		rsp_d.status         = sle_pkg::ST_OK;
		rsp_d.read_value     = '0;
		rsp_d.found_position = '0;
		case (req.op)
			sle_pkg::OP_INSERT: begin
				if (!ins_ok) begin
					rsp_d.status = sle_pkg::ST_RANGE;
				end else if (full) begin
					rsp_d.status = sle_pkg::ST_FULL;
				end else begin
					ctl.ins = valid;
					cnt_d   = cnt + sle_pkg::CNT_W'(1);
				end
			end
			sle_pkg::OP_DELETE: begin
				if (!rd_ok) begin
					rsp_d.status = sle_pkg::ST_RANGE;
				end else begin
					ctl.del = valid;
					cnt_d   = cnt - sle_pkg::CNT_W'(1);
				end
			end
			sle_pkg::OP_GET: begin
				if (!rd_ok) begin
					rsp_d.status = sle_pkg::ST_RANGE;
				end else begin
					rsp_d.read_value = entries[pos_idx];
				end
			end
			sle_pkg::OP_FIND: begin
				if (hit) begin
					rsp_d.found_position = hit_pos[4:0];
				end else begin
					rsp_d.status = sle_pkg::ST_ABSENT;
				end
			end
			default: begin
				rsp_d.status = sle_pkg::ST_RANGE;
			end
		endcase
		rsp_d.count = 5'(cnt_d);
	end

endmodule

// ===== hdl/sequential_list_engine.sv =====
// Top level of the sequential list engine: request stage, cell row, result register.
// An accepted request passes the request stage, then the result register gives its beat with done.
// Throughput: one request per cycle; busy stays low, all cells shift or compare together.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the entry count and the request and result strobes; entries stay
// undefined until written.
`timescale 1ns / 1ps
module sequential_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sle_pkg::req_t  req,
	output logic           done,
	output sle_pkg::rsp_t  rsp
);

	logic                         valid_s1;
	sle_pkg::req_t                req_s1;
	logic [sle_pkg::CNT_W-1:0]    cnt_q;
	logic [sle_pkg::CNT_W-1:0]    cnt_d;
	logic                         done_q;
	sle_pkg::rsp_t                rsp_q;
	sle_pkg::rsp_t                rsp_d;
	sle_pkg::cell_ctl_t           ctl;
	sle_pkg::entry_t              entries [sle_pkg::CAPACITY];
	logic [sle_pkg::CAPACITY-1:0] match;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
			if (valid_s1) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	sle_ctrl u_ctrl (
		.valid   (valid_s1),
		.req     (req_s1),
		.cnt     (cnt_q),
		.entries (entries),
		.match   (match),
		.ctl     (ctl),
		.cnt_d   (cnt_d),
		.rsp_d   (rsp_d)
	);

	for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
		sle_cell u_cell (
			.clk   (clk),
			.idx   (sle_pkg::IDX_W'(i)),
			.ctl   (ctl),
			.left  ((i == 0) ? entries[i] : entries[(i == 0) ? 0 : i - 1]),
			.right ((i == sle_pkg::CAPACITY - 1) ? entries[i]
			        : entries[(i == sle_pkg::CAPACITY - 1) ? i : i + 1]),
			.entry (entries[i]),
			.match (match[i])
		);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hdl/sle_checker.sv =====
// Port-level checks for the sequential list engine, bound to the top level.
`timescale 1ns / 1ps
module sle_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input sle_pkg::rsp_t rsp
);

	localparam logic [31:0] CAP_EXT = 32'(sle_pkg::CAPACITY);

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted request gave no result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a request");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == sle_pkg::ST_FULL |-> rsp.count == CAP_EXT[4:0])
		else $error("full status with count below capacity");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == sle_pkg::ST_RANGE || rsp.status == sle_pkg::ST_ABSENT)
		|-> rsp.read_value == 32'sd0 && rsp.found_position == 5'd0)
		else $error("failed request carries data");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
